@@ sv/bdac_pkg.sv @@
// Package for the banker's deadlock-avoidance core: sizes, row types, opcodes,
// status codes and configuration register indexes. No dependencies.
package bdac_pkg;

  localparam int MAX_CLIENTS = 8;
  localparam int MAX_TYPES   = 4;
  localparam int COUNT_BITS  = 8;

  localparam int CLI_W  = $clog2(MAX_CLIENTS);
  localparam int NC_W   = $clog2(MAX_CLIENTS + 1);
  localparam int NT_W   = $clog2(MAX_TYPES + 1);
  localparam int WORK_W = COUNT_BITS + $clog2(MAX_CLIENTS + 1);

  localparam int AMT_W  = 8;
  localparam int OP_W   = 3;
  localparam int CID_W  = 3;
  localparam int STAT_W = 3;
  localparam int CC_W   = 4;
  localparam int RC_W   = 3;
  localparam int CFG_W  = 4;

  localparam logic [OP_W-1:0] OP_SET_FREE = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_MAX = 3'd1;
  localparam logic [OP_W-1:0] OP_REQUEST  = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_CLI   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVER_NEED = 3'd2;
  localparam logic [STAT_W-1:0] ST_WAIT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNSAFE    = 3'd4;
  localparam logic [STAT_W-1:0] ST_OVER_HELD = 3'd5;

  localparam logic CFG_CLIENTS = 1'b0;
  localparam logic CFG_TYPES   = 1'b1;

  typedef logic [MAX_TYPES-1:0][COUNT_BITS-1:0] row_t;
  typedef logic [MAX_TYPES-1:0][WORK_W-1:0]     work_t;

endpackage

@@ sv/bankers_deadlock_avoidance_core.sv @@
// Banker's deadlock-avoidance core: free vector, per-client claim and held rows,
// and a safety walk run by one shared row comparator. Depends on bdac_pkg.
// Steps: S_EXEC checks and applies the op, S_INIT loads the work vector, then the walk,
// which scans one client row per cycle and repeats the scan while a pass finishes a
// client; S_DONE then posts the result. in_ready only while idle, so a new item is taken
// only once the last is through; a stalled result holds the next item's last step.
// Reset (synchronous): all rows, free units and scratch clear; counts go to 8 and 4.
module bankers_deadlock_avoidance_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bdac_pkg::OP_W-1:0]  opcode,
  input  logic [bdac_pkg::CID_W-1:0] client,
  input  logic [bdac_pkg::AMT_W-1:0] amount_a,
  input  logic [bdac_pkg::AMT_W-1:0] amount_b,
  input  logic [bdac_pkg::AMT_W-1:0] amount_c,
  input  logic [bdac_pkg::AMT_W-1:0] amount_d,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bdac_pkg::STAT_W-1:0] status,
  output logic                       safe,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [bdac_pkg::CFG_W-1:0] cfg_data
);
  import bdac_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [CC_W-1:0]   client_count;
  logic [RC_W-1:0]   resource_count;
  logic [OP_W-1:0]   op_q;
  logic [CID_W-1:0]  client_q;
  row_t              amt_q;
  logic [STAT_W-1:0] status_q;
  row_t              free_units;
  row_t              max_claim  [MAX_CLIENTS];
  row_t              held_units [MAX_CLIENTS];
  work_t             work_units;
  logic [MAX_CLIENTS-1:0] finished;
  logic [CLI_W-1:0]  idx;
  logic              progress;

  logic [NC_W-1:0]        nc;
  logic [NT_W-1:0]        nt;
  logic [MAX_TYPES-1:0]   type_act;
  logic [MAX_CLIENTS-1:0] cli_act;
  logic [CLI_W-1:0]       rd_idx;
  logic [CLI_W-1:0]       wr_idx;
  row_t                   max_row;
  row_t                   held_row;
  row_t                   need_row;
  row_t                   amt_in;
  logic                   bad_client;
  logic                   over_need;
  logic                   over_free;
  logic                   over_held;
  logic [STAT_W-1:0]      exec_status;
  logic                   fits;
  logic                   last;
  logic                   walk_safe;
  logic                   rollback;

  assign nc = (32'(client_count) > MAX_CLIENTS) ? NC_W'(MAX_CLIENTS) : NC_W'(client_count);
  assign nt = (32'(resource_count) > MAX_TYPES) ? NT_W'(MAX_TYPES) : NT_W'(resource_count);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign wr_idx   = CLI_W'(client_q);
  assign rd_idx   = (state == S_WALK) ? idx : wr_idx;
  assign max_row  = max_claim[rd_idx];
  assign held_row = held_units[rd_idx];

  always_comb begin
    for (int r = 0; r < MAX_TYPES; r++) begin
      type_act[r] = 32'(r) < 32'(nt);
      need_row[r] = max_row[r] - held_row[r];
      case (r)
        0:       amt_in[r] = COUNT_BITS'(amount_a);
        1:       amt_in[r] = COUNT_BITS'(amount_b);
        2:       amt_in[r] = COUNT_BITS'(amount_c);
        3:       amt_in[r] = COUNT_BITS'(amount_d);
        default: amt_in[r] = '0;
      endcase
    end
    for (int c = 0; c < MAX_CLIENTS; c++) begin
      cli_act[c] = 32'(c) < 32'(nc);
    end
  end

  always_comb begin
    over_need = 1'b0;
    over_free = 1'b0;
    over_held = 1'b0;
    fits      = (32'(idx) < 32'(nc)) && !finished[idx];
    for (int r = 0; r < MAX_TYPES; r++) begin
      if (type_act[r]) begin
        if (amt_q[r] > need_row[r])   over_need = 1'b1;
        if (amt_q[r] > free_units[r]) over_free = 1'b1;
        if (amt_q[r] > held_row[r])   over_held = 1'b1;
        if (WORK_W'(need_row[r]) > work_units[r]) fits = 1'b0;
      end
    end
  end

  assign bad_client = (op_q == OP_LOAD_MAX || op_q == OP_REQUEST || op_q == OP_RELEASE)
                      && (32'(client_q) >= 32'(nc));
  assign last       = (32'(idx) + 1) >= 32'(nc);
  assign walk_safe  = &(finished | ~cli_act);
  assign rollback   = (op_q == OP_REQUEST) && (status_q == ST_OK) && !walk_safe;

  always_comb begin
    exec_status = ST_OK;
    if (bad_client)                                exec_status = ST_BAD_CLI;
    else if (op_q == OP_REQUEST && over_need)      exec_status = ST_OVER_NEED;
    else if (op_q == OP_REQUEST && over_free)      exec_status = ST_WAIT;
    else if (op_q == OP_RELEASE && over_held)      exec_status = ST_OVER_HELD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      client_count   <= CC_W'(MAX_CLIENTS);
      resource_count <= RC_W'(MAX_TYPES);
      out_valid      <= 1'b0;
      status         <= ST_OK;
      safe           <= 1'b0;
      status_q       <= ST_OK;
      free_units     <= '0;
      work_units     <= '0;
      finished       <= '0;
      idx            <= '0;
      progress       <= 1'b0;
      for (int c = 0; c < MAX_CLIENTS; c++) begin
        max_claim[c]  <= '0;
        held_units[c] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CLIENTS) client_count <= CC_W'(cfg_data);
        else                          resource_count <= RC_W'(cfg_data);
      end
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= opcode;
            client_q <= client;
            amt_q    <= amt_in;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_q <= exec_status;
          state    <= S_INIT;
          if (exec_status == ST_OK) begin
            case (op_q)
              OP_SET_FREE: begin
                for (int r = 0; r < MAX_TYPES; r++)
                  if (type_act[r]) free_units[r] <= amt_q[r];
              end
              OP_LOAD_MAX: begin
                for (int r = 0; r < MAX_TYPES; r++)
                  if (type_act[r]) max_claim[wr_idx][r] <= amt_q[r];
                held_units[wr_idx] <= '0;
              end
              OP_REQUEST: begin
                for (int r = 0; r < MAX_TYPES; r++)
                  if (type_act[r]) begin
                    free_units[r]         <= free_units[r] - amt_q[r];
                    held_units[wr_idx][r] <= held_row[r] + amt_q[r];
                  end
              end
              OP_RELEASE: begin
                for (int r = 0; r < MAX_TYPES; r++)
                  if (type_act[r]) begin
                    held_units[wr_idx][r] <= held_row[r] - amt_q[r];
                    if ((COUNT_BITS + 1)'(free_units[r]) + (COUNT_BITS + 1)'(amt_q[r])
                        > (COUNT_BITS + 1)'({COUNT_BITS{1'b1}}))
                      free_units[r] <= {COUNT_BITS{1'b1}};
                    else
                      free_units[r] <= free_units[r] + amt_q[r];
                  end
              end
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          for (int r = 0; r < MAX_TYPES; r++)
            work_units[r] <= type_act[r] ? WORK_W'(free_units[r]) : '0;
          finished <= '0;
          idx      <= '0;
          progress <= 1'b0;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (fits) begin
            for (int r = 0; r < MAX_TYPES; r++)
              if (type_act[r]) work_units[r] <= work_units[r] + WORK_W'(held_row[r]);
            finished[idx] <= 1'b1;
          end
          if (last) begin
            idx      <= '0;
            progress <= 1'b0;
            if (!(progress || fits)) state <= S_DONE;
          end else begin
            idx      <= idx + 1'b1;
            progress <= progress || fits;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            if (rollback) begin
              for (int r = 0; r < MAX_TYPES; r++)
                if (type_act[r]) begin
                  free_units[r]         <= free_units[r] + amt_q[r];
                  held_units[wr_idx][r] <= held_row[r] - amt_q[r];
                end
            end
            status    <= rollback ? ST_UNSAFE : status_q;
            safe      <= walk_safe;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/bdac_chk.sv @@
// Port-level checker for the banker's deadlock-avoidance core and its bind.
// Depends on bdac_pkg for status codes.
module bdac_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bdac_pkg::STAT_W-1:0] status,
  input logic                        safe
);
  import bdac_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(safe))
    else $error("result beat changed while stalled");

  a_unsafe_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNSAFE |-> !safe)
    else $error("unsafe refusal reports a safe walk");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVER_HELD)
    else $error("status code out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat while busy");

endmodule

bind bankers_deadlock_avoidance_core bdac_chk u_bdac_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status), .safe(safe)
);
